// ===== rtl/prefix_code_table_decoder_core_defines.svh =====
// Assertion macros shared by the prefix code table decoder RTL.
`ifndef PREFIX_CODE_TABLE_DECODER_CORE_DEFINES_SVH
`define PREFIX_CODE_TABLE_DECODER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define HCD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcd assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define HCD_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcd assertion failed");
`else
`define HCD_ASSERT_IMP(name, ante, cons)
`define HCD_ASSERT_NXT(name, ante, cons)
`endif
`endif

// ===== rtl/hcd_pkg.sv =====
// Shared types, codes and helpers of the prefix code table decoder.
package hcd_pkg;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_DECODE = 2'd2;

  localparam logic [1:0] ST_SYMBOL     = 2'd0;
  localparam logic [1:0] ST_TABLE_FULL = 2'd1;
  localparam logic [1:0] ST_OVERFLOW   = 2'd2;

  localparam int MAX_CODE_LEN  = 32;
  localparam int BUF_LIMIT     = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
  localparam int BITS_PER_BYTE = 8;

  // One stored code table entry.
  typedef struct packed {
    logic [31:0] code;
    logic [5:0]  len;
    logic [7:0]  sym;
  } hcd_entry_t;

  // Request from the controller to the result queue.
  typedef struct packed {
    logic       push;
    logic       close;
    logic [7:0] sym;
    logic [1:0] status;
  } hcd_res_req_t;

  // Mask that keeps the low len bits of a code.
  function automatic logic [31:0] len_mask(input logic [5:0] len);
    if (len >= 6'd32) begin
      return '1;
    end
    return (32'd1 << len) - 32'd1;
  endfunction

endpackage

// ===== rtl/hcd_table_mem.sv =====
// Code table memory: one write port, one registered read port.
module hcd_table_mem
  import hcd_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  hcd_entry_t               wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output hcd_entry_t               rdata
);

  hcd_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/hcd_result_q.sv =====
// Result queue: holds one result back until its last flag is known, then outputs it.
module hcd_result_q
  import hcd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  hcd_res_req_t req,
  output logic         can_accept,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [7:0]   out_sym,
  output logic [1:0]   out_status,
  output logic         out_last
);
  `include "prefix_code_table_decoder_core_defines.svh"

  logic       pend_v_r, pend_v_nxt;
  logic [7:0] pend_sym_r, pend_sym_nxt;
  logic [1:0] pend_st_r, pend_st_nxt;
  logic       out_v_r, out_v_nxt;
  logic [7:0] out_sym_r, out_sym_nxt;
  logic [1:0] out_st_r, out_st_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_free;

  assign out_free   = !out_v_r || out_ready;
  assign can_accept = !pend_v_r || out_free;

  always_comb begin
    pend_v_nxt   = pend_v_r;
    pend_sym_nxt = pend_sym_r;
    pend_st_nxt  = pend_st_r;
    out_v_nxt    = out_v_r;
    out_sym_nxt  = out_sym_r;
    out_st_nxt   = out_st_r;
    out_last_nxt = out_last_r;
    if (out_v_r && out_ready) begin
      out_v_nxt = 1'b0;
    end
    if (req.push && can_accept) begin
      // A newer result exists, so the held one is not the last of its item.
      if (pend_v_r) begin
        out_v_nxt    = 1'b1;
        out_sym_nxt  = pend_sym_r;
        out_st_nxt   = pend_st_r;
        out_last_nxt = 1'b0;
      end
      pend_v_nxt   = 1'b1;
      pend_sym_nxt = req.sym;
      pend_st_nxt  = req.status;
    end else if (req.close && pend_v_r && out_free) begin
      out_v_nxt    = 1'b1;
      out_sym_nxt  = pend_sym_r;
      out_st_nxt   = pend_st_r;
      out_last_nxt = 1'b1;
      pend_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_sym_r <= pend_sym_nxt;
    pend_st_r  <= pend_st_nxt;
    out_sym_r  <= out_sym_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid  = out_v_r;
  assign out_sym    = out_sym_r;
  assign out_status = out_st_r;
  assign out_last   = out_last_r;

  `HCD_ASSERT_IMP(a_push_has_room, req.push, can_accept)
  `HCD_ASSERT_NXT(a_close_sets_last, req.close && pend_v_r && can_accept, out_valid && out_last)

endmodule

// ===== rtl/prefix_code_table_decoder_core.sv =====
// Top level of the prefix code table decoder: controller, table memory and result queue.
//
// Usage: items arrive on the in_ channel (valid/ready). Opcode 0 clears the code
// table and the bit buffer, opcode 1 loads one table entry, opcode 2 decodes one
// byte most significant bit first, opcode 3 is ignored. Results leave on the out_
// channel (valid/ready); out_last marks the final result caused by an item.
// Operation: one item is worked on at a time. A clear or ignored item is handled
// in the idle state. A load scans the table once and a decode byte scans it once
// per code bit, reading the stored entries one entry per cycle through the single
// read port of the table memory.
// Results wait in a one-entry holding register until the next result or the end
// of the item settles out_last, then move to the output register. A stalled
// receiver only stalls the controller when both registers are full; a new item
// is accepted while the final result of the previous one still waits.
// Reset clears the entry count, bit buffer and all valid flags; the table memory
// itself is not cleared, and only entries below the count are ever read.
module prefix_code_table_decoder_core
  import hcd_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_entry_symbol,
  input  logic [31:0] in_entry_code,
  input  logic [5:0]  in_entry_length,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_decoded_symbol,
  output logic [1:0]  out_status,
  output logic        out_last
);
  `include "prefix_code_table_decoder_core_defines.svh"

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIT,
    S_SCAN,
    S_RESOLVE,
    S_CLOSE
  } state_t;

  state_t        state_r, state_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [7:0]    sym_r, sym_nxt;
  logic [31:0]   code_r, code_nxt;
  logic [5:0]    len_r, len_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [3:0]    bit_cnt_r, bit_cnt_nxt;
  logic [31:0]   buf_r, buf_nxt;
  logic [5:0]    fill_r, fill_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] issue_idx_r, issue_idx_nxt;
  logic          cmp_v_r, cmp_v_nxt;
  logic [AW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic          hit_r, hit_nxt;
  logic [AW-1:0] hit_idx_r, hit_idx_nxt;
  logic [7:0]    hit_sym_r, hit_sym_nxt;

  // Table memory ports.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  hcd_entry_t    mem_wdata;
  logic          mem_re;
  hcd_entry_t    mem_rdata;

  hcd_res_req_t  res_req;
  logic          res_can_accept;

  // Key that the scan looks for: the loaded entry, or the current bit buffer.
  // The buffer never holds bits above its fill, so it needs no mask.
  logic [31:0]   key_code;
  logic [5:0]    key_len;
  logic          entry_match;
  logic          table_full;
  logic          need_result;

  assign key_code    = (op_r == OP_LOAD) ? code_r : buf_r;
  assign key_len     = (op_r == OP_LOAD) ? len_r : fill_r;
  assign entry_match = cmp_v_r && (mem_rdata.len == key_len) && (mem_rdata.code == key_code);
  assign table_full  = (count_r == CW'(TABLE_ENTRIES));
  assign need_result = hit_r || (fill_r >= 6'(BUF_LIMIT));
  assign in_ready    = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    sym_nxt       = sym_r;
    code_nxt      = code_r;
    len_nxt       = len_r;
    byte_nxt      = byte_r;
    bit_cnt_nxt   = bit_cnt_r;
    buf_nxt       = buf_r;
    fill_nxt      = fill_r;
    count_nxt     = count_r;
    issue_idx_nxt = issue_idx_r;
    cmp_v_nxt     = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_sym_nxt   = hit_sym_r;
    mem_we        = 1'b0;
    mem_waddr     = count_r[AW-1:0];
    mem_wdata     = '{code: code_r, len: len_r, sym: sym_r};
    mem_re        = 1'b0;
    res_req       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_opcode;
          case (in_opcode)
            OP_CLEAR: begin
              count_nxt = '0;
              buf_nxt   = '0;
              fill_nxt  = '0;
            end
            OP_LOAD: begin
              sym_nxt       = in_entry_symbol;
              code_nxt      = in_entry_code & len_mask(in_entry_length);
              len_nxt       = in_entry_length;
              issue_idx_nxt = '0;
              state_nxt     = S_SCAN;
            end
            OP_DECODE: begin
              byte_nxt    = in_data_byte;
              bit_cnt_nxt = 4'(BITS_PER_BYTE);
              state_nxt   = S_BIT;
            end
            default: begin
            end
          endcase
        end
      end

      // Shift the next data bit into the buffer and start a table scan.
      S_BIT: begin
        buf_nxt       = {buf_r[30:0], byte_r[7]};
        byte_nxt      = {byte_r[6:0], 1'b0};
        fill_nxt      = fill_r + 6'd1;
        bit_cnt_nxt   = bit_cnt_r - 4'd1;
        issue_idx_nxt = '0;
        state_nxt     = S_SCAN;
      end

      // One read is issued per cycle; its data is compared in the next cycle.
      // The first matching entry wins, as in a linear search.
      S_SCAN: begin
        if (entry_match) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = cmp_idx_r;
          hit_sym_nxt = mem_rdata.sym;
          state_nxt   = S_RESOLVE;
        end else if (issue_idx_r < count_r) begin
          mem_re        = 1'b1;
          cmp_v_nxt     = 1'b1;
          cmp_idx_nxt   = issue_idx_r[AW-1:0];
          issue_idx_nxt = issue_idx_r + CW'(1);
        end else begin
          hit_nxt   = 1'b0;
          state_nxt = S_RESOLVE;
        end
      end

      S_RESOLVE: begin
        if (op_r == OP_LOAD) begin
          if (hit_r) begin
            // Same code already stored: rewrite it with the new symbol.
            mem_we    = 1'b1;
            mem_waddr = hit_idx_r;
            state_nxt = S_IDLE;
          end else if (table_full) begin
            if (res_can_accept) begin
              res_req.push   = 1'b1;
              res_req.sym    = '0;
              res_req.status = ST_TABLE_FULL;
              state_nxt      = S_CLOSE;
            end
          end else begin
            mem_we    = 1'b1;
            count_nxt = count_r + CW'(1);
            state_nxt = S_IDLE;
          end
        end else if (!need_result || res_can_accept) begin
          if (need_result) begin
            res_req.push   = 1'b1;
            res_req.sym    = hit_r ? hit_sym_r : 8'd0;
            res_req.status = hit_r ? ST_SYMBOL : ST_OVERFLOW;
            buf_nxt        = '0;
            fill_nxt       = '0;
          end
          state_nxt = (bit_cnt_r != 4'd0) ? S_BIT : S_CLOSE;
        end
      end

      // End of item: the held result, if any, leaves with its last flag set.
      S_CLOSE: begin
        if (res_can_accept) begin
          res_req.close = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      buf_r       <= '0;
      fill_r      <= '0;
      cmp_v_r     <= 1'b0;
      issue_idx_r <= '0;
      bit_cnt_r   <= '0;
      hit_r       <= 1'b0;
      op_r        <= OP_CLEAR;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      buf_r       <= buf_nxt;
      fill_r      <= fill_nxt;
      cmp_v_r     <= cmp_v_nxt;
      issue_idx_r <= issue_idx_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      hit_r       <= hit_nxt;
      op_r        <= op_nxt;
    end
    sym_r     <= sym_nxt;
    code_r    <= code_nxt;
    len_r     <= len_nxt;
    byte_r    <= byte_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    hit_idx_r <= hit_idx_nxt;
    hit_sym_r <= hit_sym_nxt;
  end

  // Writes happen only after a scan has ended, so a later read never overlaps them.
  hcd_table_mem #(
    .DEPTH(TABLE_ENTRIES)
  ) u_table_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(issue_idx_r[AW-1:0]),
    .rdata(mem_rdata)
  );

  hcd_result_q u_result_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (res_req),
    .can_accept(res_can_accept),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_sym   (out_decoded_symbol),
    .out_status(out_status),
    .out_last  (out_last)
  );

  `HCD_ASSERT_IMP(a_count_cap, 1'b1, count_r <= CW'(TABLE_ENTRIES))
  `HCD_ASSERT_IMP(a_fill_cap, 1'b1, fill_r <= 6'(BUF_LIMIT))
  `HCD_ASSERT_IMP(a_cmp_only_in_scan, cmp_v_r, state_r == S_SCAN)
  `HCD_ASSERT_NXT(a_clear_empties, in_valid && in_ready && (in_opcode == OP_CLEAR), (count_r == '0) && (fill_r == '0))

endmodule
